// ===== rtl/left_anchored_max_rect_sum_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the left-anchored max rectangle sum unit
// Shorthand for clocked implication checks under the unit's reset.
// ----------------------------------------------------------------------------
`ifndef LEFT_ANCHORED_MAX_RECT_SUM_UNIT_ASSERT_SVH
`define LEFT_ANCHORED_MAX_RECT_SUM_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LAMRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LAMRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lamrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lamrs_pkg
// Shared constants, action codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lamrs_pkg;

	// default sizes
	localparam int DEF_MAX_ROWS   = 16;
	localparam int DEF_MAX_COLS   = 16;
	localparam int DEF_VALUE_BITS = 16;

	// result field widths
	localparam int SUM_W = 23;
	localparam int ROW_W = 4;
	localparam int WID_W = 5;
	localparam int OUT_FW = SUM_W + 2 * ROW_W + WID_W;
	localparam int OUT_DW = ((OUT_FW + 7) / 8) * 8;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// beat action codes
	localparam int ACT_W = 2;
	localparam logic [ACT_W-1:0] ACT_APPEND     = 2'd0;
	localparam logic [ACT_W-1:0] ACT_END_ROW    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_END_MATRIX = 2'd2;

	typedef struct packed {
		logic take;    // input beat accepted
		logic init;    // reset search indices and best
		logic len_rd;  // read row length of row j
		logic row;     // update width, restart row sum
		logic rd;      // read prefix of row k
		logic acc;     // add prefix into range sum
		logic cmp;     // compare range sum, advance j / i
		logic done;    // load result, clear matrix
	} lamrs_cmd_t;

	typedef struct packed {
		logic empty;   // no rows stored
		logic k_last;  // k reached j
		logic j_last;  // j is last row
		logic i_last;  // i is last row
	} lamrs_stat_t;

endpackage

// ===== rtl/left_anchored_max_rect_sum_unit.sv =====
// ----------------------------------------------------------------------------
// left_anchored_max_rect_sum_unit
// Maximum-sum rectangle anchored at column zero of a jagged matrix.
// ----------------------------------------------------------------------------
// Stream a jagged matrix in one beat per cycle: append a value, end a row, or
// end the matrix. Load beats are taken back to back. An end-of-matrix beat
// starts a search over every contiguous row range; the width of a range is
// its shortest row and its sum adds each row's prefix at that width. The
// first strictly largest sum wins (start: sum 0, all indices 0), a single
// result beat goes out, and the matrix is cleared. The search reads the
// prefix memory through its single read port: each prefix read is followed
// by its add, and every row range also does a row length read, a width
// update and a compare. No input beat is taken during the search; the
// result waits in its own register, so loading of the next matrix starts
// while that beat is still unclaimed. Rows or values beyond MAX_ROWS /
// MAX_COLS are dropped and flag overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "left_anchored_max_rect_sum_unit_assert.svh"

module left_anchored_max_rect_sum_unit
	import lamrs_pkg::*;
#(
	parameter int MAX_ROWS   = DEF_MAX_ROWS,
	parameter int MAX_COLS   = DEF_MAX_COLS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input beats
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,  // value (signed)
	input  logic [ACT_W-1:0]                     s_tuser,  // action
	// result beats
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [OUT_DW-1:0]                    m_tdata,  // best_sum, top_row,
	                                                       // bottom_row, rect_width
	output logic                                 m_tuser   // overflow
);

	lamrs_cmd_t  cmd;
	lamrs_stat_t stat;

	logic [SUM_W-1:0] best_sum;
	logic [ROW_W-1:0] top_row;
	logic [ROW_W-1:0] bottom_row;
	logic [WID_W-1:0] rect_width;
	logic             overflow;

	// sequence loading and the search
	lamrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.action   (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage, counters and arithmetic
	lamrs_dp #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.action     (s_tuser),
		.value      (s_tdata[VALUE_BITS-1:0]),
		.stat       (stat),
		.best_sum   (best_sum),
		.top_row    (top_row),
		.bottom_row (bottom_row),
		.rect_width (rect_width),
		.overflow   (overflow)
	);

	// pack the result beat, lowest field first, pad to whole bytes
	assign m_tdata = {{(OUT_DW - OUT_FW){1'b0}}, rect_width, bottom_row, top_row, best_sum};
	assign m_tuser = overflow;

	// an end-of-matrix beat closes the input until the search ends
	`LAMRS_ASSERT_NEXT(a_end_blocks_input, s_tvalid && s_tready && s_tuser == ACT_END_MATRIX, !s_tready, "input open after end of matrix")
	// a result is loaded only into a free output slot
	`LAMRS_ASSERT_NOW(a_done_slot_free, cmd.done, !m_tvalid || m_tready, "result overwrote pending beat")
	// at most one datapath command per cycle
	`LAMRS_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0({cmd.take, cmd.init, cmd.len_rd, cmd.row, cmd.rd, cmd.acc, cmd.cmp, cmd.done}), "overlapping datapath commands")

endmodule

// ===== rtl/lamrs_dp.sv =====
// ----------------------------------------------------------------------------
// lamrs_dp
// Datapath: prefix and row-length memories, load counters, search indices,
// range accumulator, best tracker and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lamrs_dp
	import lamrs_pkg::*;
#(
	parameter int MAX_ROWS   = DEF_MAX_ROWS,
	parameter int MAX_COLS   = DEF_MAX_COLS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lamrs_cmd_t                   cmd,
	input  logic [ACT_W-1:0]             action,
	input  logic signed [VALUE_BITS-1:0] value,
	output lamrs_stat_t                  stat,
	output logic [SUM_W-1:0]             best_sum,
	output logic [ROW_W-1:0]             top_row,
	output logic [ROW_W-1:0]             bottom_row,
	output logic [WID_W-1:0]             rect_width,
	output logic                         overflow
);

	localparam int RCW   = $clog2(MAX_ROWS + 1);
	localparam int CW    = $clog2(MAX_COLS + 1);
	localparam int RI    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = VALUE_BITS + CW;
	localparam int SW    = PW + RCW;
	localparam int OW    = (SW > SUM_W + 1) ? SW : SUM_W + 1;

	// load state
	logic [RCW-1:0]       row_cnt_q;
	logic [CW-1:0]        col_cnt_q;
	logic signed [PW-1:0] run_q;
	logic                 ovf_q;

	// search state
	logic [RI-1:0]        i_q, j_q, k_q;
	logic [CW-1:0]        w_q;
	logic signed [SW-1:0] sum_q;
	logic signed [SW-1:0] best_q;
	logic [RI-1:0]        bt_q, bb_q;
	logic [CW-1:0]        bw_q;

	// memories
	logic signed [PW-1:0] pfx_mem [DEPTH];
	logic [CW-1:0]        len_mem [MAX_ROWS];
	logic signed [PW-1:0] rd_q;
	logic [CW-1:0]        len_rd_q;

	// result register
	logic [SUM_W-1:0]     res_sum_q;
	logic [ROW_W-1:0]     res_top_q, res_bot_q;
	logic [WID_W-1:0]     res_wid_q;
	logic                 res_ovf_q;

	logic                 app_ok, row_full, end_row;
	logic signed [PW-1:0] run_nxt;
	logic [AW-1:0]        wr_addr, rd_addr;
	logic signed [SW-1:0] acc_term;
	logic [CW-1:0]        w_nxt;
	logic signed [OW-1:0] best_ext;
	logic [SUM_W-1:0]     best_sat;

	assign row_full = (row_cnt_q >= RCW'(MAX_ROWS));
	assign app_ok   = !row_full && (col_cnt_q < CW'(MAX_COLS));
	assign run_nxt  = run_q + PW'(value);
	assign wr_addr  = AW'(row_cnt_q * MAX_COLS + col_cnt_q);
	assign rd_addr  = AW'(k_q * MAX_COLS + w_q - 1);

	// end the current row on an explicit row end, or on matrix end with a partial row
	always_comb begin
		end_row = 1'b0;
		if (cmd.take) begin
			if (action == ACT_END_ROW)
				end_row = 1'b1;
			else if (action == ACT_END_MATRIX && col_cnt_q != '0)
				end_row = 1'b1;
		end
	end

	assign acc_term = (w_q == '0) ? SW'(0) : SW'(rd_q);
	assign w_nxt    = (j_q == i_q || len_rd_q < w_q) ? len_rd_q : w_q;

	assign best_ext = OW'(best_q);
	assign best_sat = (best_ext > OW'(SUM_MAX)) ? SUM_MAX : best_ext[SUM_W-1:0];

	assign stat.empty  = (row_cnt_q == '0);
	assign stat.k_last = (k_q == j_q);
	assign stat.j_last = ((RCW'(j_q) + RCW'(1)) == row_cnt_q);
	assign stat.i_last = ((RCW'(i_q) + RCW'(1)) == row_cnt_q);

	// memories: no reset, a read of an unwritten entry is never used
	always_ff @(posedge clk) begin
		if (cmd.take && action == ACT_APPEND && app_ok)
			pfx_mem[wr_addr] <= run_nxt;
		if (end_row && !row_full)
			len_mem[row_cnt_q[RI-1:0]] <= col_cnt_q;
		if (cmd.rd)
			rd_q <= pfx_mem[rd_addr];
		if (cmd.len_rd)
			len_rd_q <= len_mem[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= '0;
			col_cnt_q <= '0;
			run_q     <= '0;
			ovf_q     <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
		end else begin
			if (cmd.take && action == ACT_APPEND) begin
				if (app_ok) begin
					run_q     <= run_nxt;
					col_cnt_q <= col_cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (end_row) begin
				if (row_full)
					ovf_q <= 1'b1;
				else
					row_cnt_q <= row_cnt_q + RCW'(1);
				col_cnt_q <= '0;
				run_q     <= '0;
			end
			if (cmd.init) begin
				i_q <= '0;
				j_q <= '0;
			end
			if (cmd.row)
				k_q <= i_q;
			if (cmd.acc && !stat.k_last)
				k_q <= k_q + RI'(1);
			if (cmd.cmp) begin
				if (stat.j_last) begin
					i_q <= i_q + RI'(1);
					j_q <= i_q + RI'(1);
				end else begin
					j_q <= j_q + RI'(1);
				end
			end
			if (cmd.done) begin
				row_cnt_q <= '0;
				col_cnt_q <= '0;
				run_q     <= '0;
				ovf_q     <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			best_q <= '0;
			bt_q   <= '0;
			bb_q   <= '0;
			bw_q   <= '0;
		end
		if (cmd.row) begin
			w_q   <= w_nxt;
			sum_q <= '0;
		end
		if (cmd.acc)
			sum_q <= sum_q + acc_term;
		if (cmd.cmp && sum_q > best_q) begin
			best_q <= sum_q;
			bt_q   <= i_q;
			bb_q   <= j_q;
			bw_q   <= w_q;
		end
		if (cmd.done) begin
			res_sum_q <= best_sat;
			res_top_q <= ROW_W'(bt_q);
			res_bot_q <= ROW_W'(bb_q);
			res_wid_q <= WID_W'(bw_q);
			res_ovf_q <= ovf_q;
		end
	end

	assign best_sum   = res_sum_q;
	assign top_row    = res_top_q;
	assign bottom_row = res_bot_q;
	assign rect_width = res_wid_q;
	assign overflow   = res_ovf_q;

endmodule

// ===== rtl/lamrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lamrs_ctrl
// Controller: accepts load beats, sequences the range search, owns the
// result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lamrs_ctrl
	import lamrs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic [ACT_W-1:0] action,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  lamrs_stat_t      stat,
	output lamrs_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_LEN,
		ST_ROW,
		ST_RD,
		ST_ACC,
		ST_CMP,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   slot_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign slot_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd        = '0;
		cmd.take   = s_tvalid && s_tready;
		cmd.init   = (state_q == ST_START);
		cmd.len_rd = (state_q == ST_LEN);
		cmd.row    = (state_q == ST_ROW);
		cmd.rd     = (state_q == ST_RD);
		cmd.acc    = (state_q == ST_ACC);
		cmd.cmp    = (state_q == ST_CMP);
		cmd.done   = (state_q == ST_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.take && action == ACT_END_MATRIX)
						state_q <= ST_START;
				end
				ST_START: begin
					state_q <= stat.empty ? ST_DONE : ST_LEN;
				end
				ST_LEN: begin
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					state_q <= stat.k_last ? ST_CMP : ST_RD;
				end
				ST_CMP: begin
					state_q <= (stat.j_last && stat.i_last) ? ST_DONE : ST_LEN;
				end
				ST_DONE: begin
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
